// ----- hdl/sx7_pkg.sv -----
package sx7_pkg;

   localparam int unsigned MaxLen = 65535;
   localparam int unsigned PayloadMax = 6;

   localparam logic [3:0] PacketType = 4'd3;

   localparam logic [1:0] KindComplete = 2'd0;
   localparam logic [1:0] KindStart    = 2'd1;
   localparam logic [1:0] KindContinue = 2'd2;
   localparam logic [1:0] KindEnd      = 2'd3;

   localparam logic OpBegin = 1'b0;
   localparam logic OpData  = 1'b1;

   typedef struct packed {
      logic        op;
      logic [23:0] manufacturer_id;
      logic [15:0] data_length;
      logic [3:0]  group_number;
      logic [7:0]  data_byte;
   } req_type;

endpackage

// ----- hdl/sx7_req_if.sv -----
interface sx7_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [23:0] manufacturer_id;
   logic [15:0] data_length;
   logic [3:0]  group_number;
   logic [7:0]  data_byte;

   modport source (output valid, op, manufacturer_id, data_length, group_number, data_byte,
                   input ready);
   modport sink (input valid, op, manufacturer_id, data_length, group_number, data_byte,
                 output ready);
endinterface

// ----- hdl/sx7_rsp_if.sv -----
interface sx7_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] packet;
   logic        last_packet;

   modport source (output valid, packet, last_packet, input ready);
   modport sink (input valid, packet, last_packet, output ready);
endinterface

// ----- hdl/sx7_in_reg.sv -----
module sx7_in_reg (
   input  logic             clock,
   input  logic             reset,
   sx7_req_if.sink          req,
   output logic             item_valid,
   output sx7_pkg::req_type item,
   input  logic             item_ready
);

   logic             valid_ff;
   logic             valid_in;
   sx7_pkg::req_type item_ff;
   logic             load;

   assign req.ready = !valid_ff || item_ready;
   assign load = req.valid && req.ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (item_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.op              <= req.op;
         item_ff.manufacturer_id <= req.manufacturer_id;
         item_ff.data_length     <= req.data_length;
         item_ff.group_number    <= req.group_number;
         item_ff.data_byte       <= req.data_byte;
      end
   end

   assign item_valid = valid_ff;
   assign item = item_ff;

endmodule

// ----- hdl/sx7_pack.sv -----
module sx7_pack (
   input  logic             clock,
   input  logic             reset,
   input  logic             item_valid,
   input  sx7_pkg::req_type item,
   output logic             item_ready,
   sx7_rsp_if.source        rsp
);

   logic        open_ff, open_in;
   logic [15:0] remaining_ff, remaining_in;
   logic [2:0]  fill_ff, fill_in;
   logic [47:0] buffer_ff, buffer_in;
   logic [1:0]  kind_ff, kind_in;
   logic [3:0]  group_ff, group_in;

   logic        out_valid_ff, out_valid_in;
   logic [63:0] packet_ff, packet_in;
   logic        last_ff, last_in;

   logic        fire;
   logic        emit;
   logic [15:0] len_sat;
   logic [1:0]  id_bytes;
   logic [16:0] total;
   logic [2:0]  fill_next;
   logic [47:0] buffer_next;
   logic [15:0] remaining_next;

   assign item_ready = !out_valid_ff || rsp.ready;
   assign fire = item_valid && item_ready;

   always_comb begin
      open_in      = open_ff;
      remaining_in = remaining_ff;
      fill_in      = fill_ff;
      buffer_in    = buffer_ff;
      kind_in      = kind_ff;
      group_in     = group_ff;
      emit         = 1'b0;
      packet_in    = packet_ff;
      last_in      = last_ff;

      len_sat = (32'(item.data_length) > sx7_pkg::MaxLen) ?
                16'(sx7_pkg::MaxLen) : item.data_length;
      id_bytes = (item.manufacturer_id[15:0] != 16'd0) ? 2'd3 : 2'd1;
      total = {1'b0, len_sat} + 17'(id_bytes);

      fill_next = (fill_ff < 3'(sx7_pkg::PayloadMax)) ? fill_ff + 3'd1 : fill_ff;
      buffer_next = buffer_ff;
      for (int k = 0; k < 6; k++) begin
         if (fill_ff == 3'(k)) begin
            buffer_next[47 - 8 * k -: 8] = {1'b0, item.data_byte[6:0]};
         end
      end
      remaining_next = remaining_ff - 16'd1;

      if (fire) begin
         if (item.op == sx7_pkg::OpBegin) begin
            group_in = item.group_number;
            kind_in = (total <= 17'(sx7_pkg::PayloadMax)) ?
                      sx7_pkg::KindComplete : sx7_pkg::KindStart;
            if (id_bytes == 2'd3) begin
               buffer_in = {1'b0, item.manufacturer_id[22:16],
                            1'b0, item.manufacturer_id[14:8],
                            1'b0, item.manufacturer_id[6:0], 24'd0};
               fill_in = 3'd3;
            end else begin
               buffer_in = {1'b0, item.manufacturer_id[22:16], 40'd0};
               fill_in = 3'd1;
            end
            remaining_in = len_sat;
            if (len_sat == 16'd0) begin
               emit = 1'b1;
               packet_in = {sx7_pkg::PacketType, item.group_number, 2'b00, kind_in,
                            1'b0, fill_in, buffer_in};
               last_in = 1'b1;
               open_in = 1'b0;
               fill_in = 3'd0;
               buffer_in = 48'd0;
            end else begin
               open_in = 1'b1;
            end
         end else if (open_ff) begin
            fill_in = fill_next;
            buffer_in = buffer_next;
            remaining_in = remaining_next;
            if (fill_next >= 3'(sx7_pkg::PayloadMax) || remaining_next == 16'd0) begin
               emit = 1'b1;
               packet_in = {sx7_pkg::PacketType, group_ff, 2'b00, kind_ff,
                            1'b0, fill_next, buffer_next};
               last_in = (remaining_next == 16'd0);
               fill_in = 3'd0;
               buffer_in = 48'd0;
               if (remaining_next == 16'd0) begin
                  open_in = 1'b0;
               end else begin
                  kind_in = (remaining_next <= 16'(sx7_pkg::PayloadMax)) ?
                            sx7_pkg::KindEnd : sx7_pkg::KindContinue;
               end
            end
         end
      end

      if (fire && emit) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff      <= 1'b0;
         remaining_ff <= 16'd0;
         fill_ff      <= 3'd0;
         buffer_ff    <= 48'd0;
         kind_ff      <= sx7_pkg::KindComplete;
         group_ff     <= 4'd0;
         out_valid_ff <= 1'b0;
      end else begin
         open_ff      <= open_in;
         remaining_ff <= remaining_in;
         fill_ff      <= fill_in;
         buffer_ff    <= buffer_in;
         kind_ff      <= kind_in;
         group_ff     <= group_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && emit) begin
         packet_ff <= packet_in;
         last_ff   <= last_in;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.packet = packet_ff;
   assign rsp.last_packet = last_ff;

endmodule

// ----- hdl/sysex7_ump_packetizer.sv -----
// Packs seven-bit system-exclusive messages into 64-bit universal packets of message
// type 3. A begin transaction carries the manufacturer ID, the data length and the
// group; each data transaction adds one byte. The block takes one transaction per
// cycle while the sink keeps up: each transaction is registered at the input, packed
// in one pass against the message state, and any finished packet is held in an output
// register. While a packet waits for the sink, packing stalls and the input register
// takes at most one more transaction. Data transactions with no open message are
// dropped, and a new begin discards any partly filled packet.
module sysex7_ump_packetizer (
   input logic       clock,
   input logic       reset,
   sx7_req_if.sink   req_chan,
   sx7_rsp_if.source rsp_chan
);

   logic             item_valid;
   logic             item_ready;
   sx7_pkg::req_type item;

   sx7_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .item_valid (item_valid),
      .item       (item),
      .item_ready (item_ready)
   );

   sx7_pack u_pack (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_ready (item_ready),
      .rsp        (rsp_chan)
   );

   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.packet[51:48] != 4'd0 && rsp_chan.packet[51:48] <= 4'd6)
      else $error("Packet byte count out of range.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.packet[53:52] == sx7_pkg::KindComplete
      |-> rsp_chan.last_packet)
      else $error("Complete packet not marked as final.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.packet[53:52] == sx7_pkg::KindStart
      |-> !rsp_chan.last_packet && rsp_chan.packet[51:48] == 4'd6)
      else $error("Start packet is final or not full.");

endmodule

// ----- test/sx7_packet_checker.sv -----
module sx7_packet_checker (
   input logic  clock,
   input logic  reset,
   sx7_req_if   req_mon,
   sx7_rsp_if   rsp_mon,
   output int   mismatches,
   output int   packets_owed
);

   typedef struct packed {
      logic [63:0] packet;
      logic        last_packet;
   } sx7_packet_type;

   sx7_packet_type packets_due[$];

   logic        msg_open;
   logic [15:0] bytes_left;
   logic [2:0]  fill;
   logic [47:0] payload;
   logic [1:0]  kind;
   logic [3:0]  group_held;
   int          fail_count = 0;

   task automatic add_byte(input logic [7:0] b);
      if (fill < 3'(sx7_pkg::PayloadMax)) begin
         payload[47 - 8 * fill -: 8] = {1'b0, b[6:0]};
         fill = fill + 3'd1;
      end
   endtask

   task automatic emit_packet(input logic last);
      sx7_packet_type p;
      p.packet = {sx7_pkg::PacketType, group_held, 2'b00, kind, 1'b0, fill, payload};
      p.last_packet = last;
      packets_due = {packets_due, p};
      fill = '0;
      payload = '0;
   endtask

   task automatic pack_transaction(input sx7_pkg::req_type t);
      int unsigned len;
      logic        three_ids;
      if (t.op == sx7_pkg::OpBegin) begin
         three_ids = (t.manufacturer_id[15:0] != 16'h0);
         len = t.data_length;
         if (len > sx7_pkg::MaxLen) begin
            len = sx7_pkg::MaxLen;
         end
         group_held = t.group_number;
         fill = '0;
         payload = '0;
         kind = (len + (three_ids ? 3 : 1) <= sx7_pkg::PayloadMax) ?
                sx7_pkg::KindComplete : sx7_pkg::KindStart;
         add_byte(t.manufacturer_id[23:16]);
         if (three_ids) begin
            add_byte(t.manufacturer_id[15:8]);
            add_byte(t.manufacturer_id[7:0]);
         end
         bytes_left = len[15:0];
         if (bytes_left == 16'd0) begin
            emit_packet(1'b1);
            msg_open = 1'b0;
         end else begin
            msg_open = 1'b1;
         end
      end else if (msg_open) begin
         add_byte(t.data_byte);
         bytes_left = bytes_left - 16'd1;
         if (fill >= 3'(sx7_pkg::PayloadMax) || bytes_left == 16'd0) begin
            emit_packet(bytes_left == 16'd0);
            if (bytes_left == 16'd0) begin
               msg_open = 1'b0;
            end else begin
               kind = (bytes_left <= 16'(sx7_pkg::PayloadMax)) ?
                      sx7_pkg::KindEnd : sx7_pkg::KindContinue;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      sx7_packet_type due;
      if (reset) begin
         msg_open = 1'b0;
         bytes_left = '0;
         fill = '0;
         payload = '0;
         kind = sx7_pkg::KindComplete;
         group_held = '0;
         packets_due.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            pack_transaction({req_mon.op, req_mon.manufacturer_id, req_mon.data_length,
                              req_mon.group_number, req_mon.data_byte});
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (packets_due.size() == 0) begin
               $display("%0t: no packet expected, got %h last %b", $time,
                        rsp_mon.packet, rsp_mon.last_packet);
               fail_count++;
            end else begin
               due = packets_due.pop_front();
               if (rsp_mon.packet !== due.packet) begin
                  $display("%0t: packet expected %h, got %h", $time,
                           due.packet, rsp_mon.packet);
                  fail_count++;
               end
               if (rsp_mon.last_packet !== due.last_packet) begin
                  $display("%0t: last_packet expected %b, got %b", $time,
                           due.last_packet, rsp_mon.last_packet);
                  fail_count++;
               end
            end
         end
      end
      mismatches <= fail_count;
      packets_owed <= packets_due.size();
   end

endmodule

// ----- test/tb_top.sv -----
module tb_top;

   logic clock;
   logic reset;

   sx7_req_if req_chan();
   sx7_rsp_if rsp_chan();

   int          mismatches;
   int          packets_owed;
   int          quiet_cycles;
   int unsigned sent;
   bit          calm;
   bit          hold_off_req;
   bit          hold_done;
   logic [7:0]  byte_pattern [10] = '{8'hFF, 8'h80, 8'h00, 8'h7F, 8'h55,
                                      8'hAA, 8'h01, 8'hFE, 8'h40, 8'h3C};

   sysex7_ump_packetizer dut (
      .clock,
      .reset,
      .req_chan,
      .rsp_chan
   );

   sx7_packet_checker packet_check (
      .clock,
      .reset,
      .req_mon(req_chan),
      .rsp_mon(rsp_chan),
      .mismatches,
      .packets_owed
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic sx7_pkg::req_type scrambled(input logic op);
      sx7_pkg::req_type t;
      logic [31:0]      a;
      logic [31:0]      b;
      a = $urandom;
      b = $urandom;
      t.op = op;
      t.manufacturer_id = a[23:0];
      t.data_length = b[15:0];
      t.group_number = b[19:16];
      t.data_byte = b[27:20];
      return t;
   endfunction

   function automatic logic [23:0] random_id();
      logic [31:0] w;
      w = $urandom;
      return w[31] ? {w[7:0], 16'h0000} : w[23:0];
   endfunction

   task automatic offer(input sx7_pkg::req_type t);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.op <= t.op;
      req_chan.manufacturer_id <= t.manufacturer_id;
      req_chan.data_length <= t.data_length;
      req_chan.group_number <= t.group_number;
      req_chan.data_byte <= t.data_byte;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic send_begin(input logic [23:0] id, input logic [15:0] len,
                             input logic [3:0] grp);
      sx7_pkg::req_type t;
      t = scrambled(sx7_pkg::OpBegin);
      t.manufacturer_id = id;
      t.data_length = len;
      t.group_number = grp;
      offer(t);
      sent++;
   endtask

   task automatic send_data(input logic [7:0] b, input bit counted);
      sx7_pkg::req_type t;
      t = scrambled(sx7_pkg::OpData);
      t.data_byte = b;
      offer(t);
      if (counted) begin
         sent++;
      end
   endtask

   initial begin
      wait (reset === 1'b0);
      forever begin
         if (hold_off_req && !hold_done) begin
            rsp_chan.ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_done = 1'b1;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= 2000) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int          n;
      int          n_data;
      bit          left_open;
      logic [31:0] w;
      logic [15:0] len16;

      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.op <= sx7_pkg::OpBegin;
      req_chan.manufacturer_id <= '0;
      req_chan.data_length <= '0;
      req_chan.group_number <= '0;
      req_chan.data_byte <= '0;
      rsp_chan.ready <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Stray data, empty messages, a message through every kind but complete,
      // an abandoned maximum-length message, and a last byte that fills a packet.
      send_data(8'hFF, 1'b0);
      send_begin(24'h7F0000, 16'd0, 4'd0);
      send_begin(24'hFFFFFF, 16'd0, 4'd15);
      send_begin(24'h000001, 16'd10, 4'd9);
      for (int i = 0; i < 10; i++) send_data(byte_pattern[i], 1'b1);
      send_begin(24'h430000, 16'hFFFF, 4'd3);
      send_data(8'hC3, 1'b1);
      send_data(8'h3C, 1'b1);
      send_begin(24'h800000, 16'd5, 4'd6);
      for (int i = 0; i < 5; i++) send_data(byte_pattern[9 - i], 1'b1);

      left_open = 1'b0;
      while (sent < 450) begin
         if (sent >= 100) begin
            hold_off_req = 1'b1;
         end
         if (sent >= 380) begin
            calm = 1'b1;
         end
         w = $urandom;
         n = $urandom_range(0, 19);
         if (n < 16) begin
            n_data = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            len16 = n_data[15:0];
            send_begin(random_id(), len16, w[3:0]);
            for (int i = 0; i < n_data; i++) begin
               w = $urandom;
               send_data(w[7:0], 1'b1);
            end
            left_open = 1'b0;
         end else if (n < 18) begin
            if (left_open) begin
               send_begin(random_id(), 16'd0, w[3:0]);
               left_open = 1'b0;
            end
            repeat ($urandom_range(1, 3)) begin
               w = $urandom;
               send_data(w[7:0], 1'b0);
            end
         end else begin
            len16 = w[31:16];
            if (len16 == 16'd0) begin
               len16 = 16'd1;
            end
            n_data = $urandom_range(0, 8);
            if (n_data >= len16) begin
               n_data = len16 - 1;
            end
            send_begin(random_id(), len16, w[3:0]);
            for (int i = 0; i < n_data; i++) begin
               w = $urandom;
               send_data(w[7:0], 1'b1);
            end
            left_open = 1'b1;
         end
      end
      req_chan.valid <= 1'b0;

      repeat (2) @(posedge clock);
      while (packets_owed != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0 && packets_owed == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
